// File: rtl/core/fspd_pkg.sv
package fspd_pkg;

   localparam int CH_W       = 8;
   localparam int IDX_W      = 8;
   localparam int KEY_W      = 15;
   localparam int CACHE_DEPTH = 32768;
   localparam int ERR_W      = 25;
   localparam int SIDE_W     = 16;
   localparam int DIST_W     = 18;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [1:0] MODE_PIXEL = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_FRAME = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DITHER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_WIDTH    = 2'd2;

   localparam logic [8:0]  PALETTE_SIZE_RESET = 9'd256;
   localparam logic [12:0] LINE_WIDTH_RESET   = 13'd640;

   localparam logic [7:0] BUCKET_MASK = 8'hf8;

   localparam logic signed [ERR_W-1:0] W_SEVEN = 25'sd14336;
   localparam logic signed [ERR_W-1:0] W_FIVE  = 25'sd10240;
   localparam logic signed [ERR_W-1:0] W_THREE = 25'sd6144;
   localparam logic signed [ERR_W-1:0] W_ONE   = 25'sd2048;

   typedef struct packed {
      logic take;
      logic clear_step;
      logic hit_take;
      logic search_start;
      logic search_run;
      logic fill;
      logic err;
      logic rd1;
      logic rd2;
      logic rd3;
      logic finish;
   } fspd_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic cache_hit;
      logic search_done;
      logic dither_on;
      logic out_free;
   } fspd_status_type;

endpackage

// File: rtl/core/floyd_steinberg_palette_ditherer_core.sv
// Floyd-Steinberg palette ditherer: one item at a time. Load and unused-mode items
// are taken without leaving the idle state. A pixel looks up its colour bucket in
// the cache; a miss adds a palette walk (one entry per cycle through a three-stage
// distance pipeline) and a cache fill. With dithering on, the error is then spread
// by a read-modify-write of three words in each line store, which has one read and
// one write port. After reset and after every frame start item the block runs a
// clearing pass over the bucket cache and the line stores, during which no item is
// taken; configuration writes are taken at any time. A finished result waits in an
// output register while the next item is taken.
module floyd_steinberg_palette_ditherer_core #(
   parameter int MAX_WIDTH     = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_mode,
   input  logic [fspd_pkg::CH_W-1:0]       req_red,
   input  logic [fspd_pkg::CH_W-1:0]       req_green,
   input  logic [fspd_pkg::CH_W-1:0]       req_blue,
   input  logic [fspd_pkg::IDX_W-1:0]      req_entry_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [fspd_pkg::IDX_W-1:0]      rsp_palette_index,
   input  logic                            csr_write_enable,
   input  logic [fspd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fspd_pkg::CSR_DATA_W-1:0] csr_write_data
);

   fspd_pkg::fspd_cmd_type    cmd;
   fspd_pkg::fspd_status_type status;

   fspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   fspd_datapath #(
      .MAX_WIDTH     (MAX_WIDTH),
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_mode),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_entry_index   (req_entry_index),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_palette_index (rsp_palette_index)
   );

endmodule

// File: rtl/core/fspd_ctrl.sv
module fspd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_mode,
   input  fspd_pkg::fspd_status_type status,
   output logic                     req_stall,
   output fspd_pkg::fspd_cmd_type    cmd
);

   localparam logic [3:0] ST_CLEAR  = 4'd0;
   localparam logic [3:0] ST_IDLE   = 4'd1;
   localparam logic [3:0] ST_LOOK   = 4'd2;
   localparam logic [3:0] ST_HIT    = 4'd3;
   localparam logic [3:0] ST_SEARCH = 4'd4;
   localparam logic [3:0] ST_FILL   = 4'd5;
   localparam logic [3:0] ST_PAL    = 4'd6;
   localparam logic [3:0] ST_ERR    = 4'd7;
   localparam logic [3:0] ST_RD1    = 4'd8;
   localparam logic [3:0] ST_RD2    = 4'd9;
   localparam logic [3:0] ST_RD3    = 4'd10;
   localparam logic [3:0] ST_DONE   = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_mode == fspd_pkg::MODE_PIXEL) begin
                  state_in = ST_LOOK;
               end else if (req_mode == fspd_pkg::MODE_FRAME) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_LOOK: begin
            state_in = ST_HIT;
         end
         ST_HIT: begin
            if (status.cache_hit) begin
               cmd.hit_take = 1'b1;
               state_in     = ST_PAL;
            end else begin
               cmd.search_start = 1'b1;
               state_in         = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_run = 1'b1;
            if (status.search_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            cmd.fill = 1'b1;
            state_in = ST_PAL;
         end
         ST_PAL: begin
            state_in = status.dither_on ? ST_ERR : ST_DONE;
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            cmd.rd1  = 1'b1;
            state_in = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd2  = 1'b1;
            state_in = ST_RD3;
         end
         ST_RD3: begin
            cmd.rd3  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: rtl/core/fspd_datapath.sv
module fspd_datapath #(
   parameter int MAX_WIDTH     = 4096,
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fspd_pkg::fspd_cmd_type                cmd,
   output fspd_pkg::fspd_status_type             status,
   input  logic [1:0]                           req_mode,
   input  logic [fspd_pkg::CH_W-1:0]            req_red,
   input  logic [fspd_pkg::CH_W-1:0]            req_green,
   input  logic [fspd_pkg::CH_W-1:0]            req_blue,
   input  logic [fspd_pkg::IDX_W-1:0]           req_entry_index,
   input  logic                                 csr_write_enable,
   input  logic [fspd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fspd_pkg::CSR_DATA_W-1:0]      csr_write_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output logic [fspd_pkg::IDX_W-1:0]           rsp_palette_index
);

   localparam int LINE_DEPTH = MAX_WIDTH + 3;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int LAW        = $clog2(LINE_DEPTH);
   localparam int PAW        = $clog2(PALETTE_DEPTH);
   localparam int CLR_N      = (LINE_DEPTH > fspd_pkg::CACHE_DEPTH) ?
                               LINE_DEPTH : fspd_pkg::CACHE_DEPTH;
   localparam int CW         = $clog2(CLR_N);
   localparam int EW         = fspd_pkg::ERR_W;
   localparam int SW         = fspd_pkg::SIDE_W;

   // configuration
   logic        dither_ff;
   logic [8:0]  psize_ff;
   logic [12:0] lwidth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= 1'b1;
         psize_ff  <= fspd_pkg::PALETTE_SIZE_RESET;
         lwidth_ff <= fspd_pkg::LINE_WIDTH_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fspd_pkg::CSR_DITHER_ENABLE: dither_ff <= csr_write_data[0];
            fspd_pkg::CSR_PALETTE_SIZE:  psize_ff  <= csr_write_data[8:0];
            fspd_pkg::CSR_LINE_WIDTH:    lwidth_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   logic [WW-1:0] eff_w;
   logic [31:0]   lw32;
   logic [8:0]    eff_n;

   always_comb begin
      lw32 = 32'(lwidth_ff);
      if (lwidth_ff == '0) begin
         eff_w = WW'(1);
      end else if (lw32 > 32'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(lw32);
      end
      if (psize_ff == '0) begin
         eff_n = 9'd1;
      end else if (psize_ff > 9'(PALETTE_DEPTH)) begin
         eff_n = 9'(PALETTE_DEPTH);
      end else begin
         eff_n = psize_ff;
      end
   end

   // item capture
   logic take_pixel;
   logic take_frame;
   logic take_load;

   assign take_pixel = cmd.take && (req_mode == fspd_pkg::MODE_PIXEL);
   assign take_frame = cmd.take && (req_mode == fspd_pkg::MODE_FRAME);
   assign take_load  = cmd.take && (req_mode == fspd_pkg::MODE_LOAD);

   logic [WW-1:0]          col_ff;
   logic [WW-1:0]          x_ff;
   logic signed [SW-1:0]   side_ff  [3];
   logic [7:0]             pix_ff   [3];
   logic [7:0]             in_c     [3];
   logic [7:0]             pix_in   [3];
   logic signed [SW-1:0]   side_eff [3];
   logic signed [16:0]     adj_diff [3];
   logic                   wrap_now;

   assign in_c[0]  = req_red;
   assign in_c[1]  = req_green;
   assign in_c[2]  = req_blue;
   assign wrap_now = (col_ff >= eff_w);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         side_eff[c] = wrap_now ? '0 : side_ff[c];
         adj_diff[c] = $signed({9'b0, in_c[c]}) - $signed({side_eff[c][SW-1], side_eff[c]});
         if (!dither_ff) begin
            pix_in[c] = in_c[c];
         end else if (adj_diff[c] < 0) begin
            pix_in[c] = '0;
         end else if (adj_diff[c] > 17'sd255) begin
            pix_in[c] = 8'hff;
         end else begin
            pix_in[c] = adj_diff[c][7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel) begin
         x_ff <= wrap_now ? '0 : col_ff;
         for (int c = 0; c < 3; c++) begin
            pix_ff[c] <= pix_in[c];
         end
      end
   end

   // palette memory
   logic [23:0]       pal_mem [PALETTE_DEPTH];
   logic [23:0]       pal_q_ff;
   logic [PAW-1:0]    pal_raddr;
   logic              pal_we;
   logic [8:0]        scnt_ff;
   logic [7:0]        idx_ff;

   assign pal_we    = take_load && ({1'b0, req_entry_index} < 9'(PALETTE_DEPTH));
   assign pal_raddr = cmd.search_run ? scnt_ff[PAW-1:0] : idx_ff[PAW-1:0];

   always_ff @(posedge clock) begin
      if (pal_we) begin
         pal_mem[req_entry_index[PAW-1:0]] <= {req_red, req_green, req_blue};
      end
      pal_q_ff <= pal_mem[pal_raddr];
   end

   // palette entry minus pixel, per channel
   logic signed [8:0]  sdiff [3];
   logic signed [17:0] sprod [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sdiff[c] = $signed({1'b0, pal_q_ff[23-8*c -: 8]}) - $signed({1'b0, pix_ff[c]});
         sprod[c] = sdiff[c] * sdiff[c];
      end
   end

   // palette search
   logic                          v1_ff;
   logic                          v2_ff;
   logic [7:0]                    i1_ff;
   logic [7:0]                    i2_ff;
   logic [15:0]                   sq_ff [3];
   logic [fspd_pkg::DIST_W-1:0]   best_d_ff;
   logic [7:0]                    best_ff;
   logic [fspd_pkg::DIST_W-1:0]   dsum;
   logic                          issue;

   assign issue = cmd.search_run && (scnt_ff < eff_n);
   assign dsum  = 18'(sq_ff[0]) + 18'(sq_ff[1]) + 18'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (cmd.search_start) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_start) begin
         scnt_ff   <= '0;
         best_d_ff <= '1;
         best_ff   <= '0;
      end else begin
         if (issue) begin
            scnt_ff <= scnt_ff + 9'd1;
         end
         if (v2_ff && (dsum < best_d_ff)) begin
            best_d_ff <= dsum;
            best_ff   <= i2_ff;
         end
      end
      i1_ff <= scnt_ff[7:0];
      i2_ff <= i1_ff;
      for (int c = 0; c < 3; c++) begin
         sq_ff[c] <= sprod[c][15:0];
      end
   end

   // clearing pass
   logic [CW-1:0] clr_cnt_ff;
   logic          clr_in_cache;
   logic          clr_in_line;

   assign clr_in_cache = ({1'b0, clr_cnt_ff} < (CW+1)'(fspd_pkg::CACHE_DEPTH));
   assign clr_in_line  = ({1'b0, clr_cnt_ff} < (CW+1)'(LINE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset || take_frame) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_cnt_ff <= clr_cnt_ff + CW'(1);
      end
   end

   // bucket cache
   logic [8:0]                  cache_mem [fspd_pkg::CACHE_DEPTH];
   logic [8:0]                  cache_q_ff;
   logic [fspd_pkg::KEY_W-1:0]  key;
   logic [fspd_pkg::KEY_W-1:0]  cache_waddr;
   logic                        cache_we;
   logic [8:0]                  cache_wdata;

   assign key = {pix_ff[0][7:3], pix_ff[1][7:3], pix_ff[2][7:3]};
   assign cache_we    = (cmd.clear_step && clr_in_cache) || cmd.fill;
   assign cache_waddr = cmd.clear_step ? clr_cnt_ff[fspd_pkg::KEY_W-1:0] : key;
   assign cache_wdata = cmd.clear_step ? 9'd0 : {1'b1, best_ff};

   always_ff @(posedge clock) begin
      if (cache_we) begin
         cache_mem[cache_waddr] <= cache_wdata;
      end
      cache_q_ff <= cache_mem[key];
   end

   always_ff @(posedge clock) begin
      if (cmd.hit_take) begin
         idx_ff <= cache_q_ff[7:0];
      end else if (cmd.fill) begin
         idx_ff <= best_ff;
      end
   end

   // line stores
   logic [LAW-1:0]        xl;
   logic [LAW-1:0]        line_waddr;
   logic [LAW-1:0]        line_raddr;
   logic                  line_we;
   logic signed [8:0]     err_ff   [3];
   logic signed [EW-1:0]  line_q_ff [3];
   logic signed [EW-1:0]  e25      [3];
   logic signed [EW-1:0]  line_wdata [3];
   logic signed [26:0]    side_sum [3];
   logic signed [SW-1:0]  side_new [3];

   assign xl         = LAW'(x_ff);
   assign line_we    = (cmd.clear_step && clr_in_line) || cmd.rd1 || cmd.rd2 || cmd.rd3;
   assign line_raddr = cmd.err ? (xl + LAW'(2)) : (cmd.rd1 ? (xl + LAW'(1)) : xl);

   always_comb begin
      priority if (cmd.clear_step) begin
         line_waddr = clr_cnt_ff[LAW-1:0];
      end else if (cmd.rd1) begin
         line_waddr = xl + LAW'(2);
      end else if (cmd.rd2) begin
         line_waddr = xl + LAW'(1);
      end else begin
         line_waddr = xl;
      end
      for (int c = 0; c < 3; c++) begin
         e25[c]      = EW'(err_ff[c]);
         side_sum[c] = 27'(line_q_ff[c]) + 27'(e25[c] * fspd_pkg::W_SEVEN);
         side_new[c] = SW'($signed(side_sum[c][26:15]));
         priority if (cmd.clear_step) begin
            line_wdata[c] = '0;
         end else if (cmd.rd1) begin
            line_wdata[c] = e25[c] * fspd_pkg::W_ONE;
         end else if (cmd.rd2) begin
            line_wdata[c] = line_q_ff[c] + e25[c] * fspd_pkg::W_FIVE;
         end else begin
            line_wdata[c] = line_q_ff[c] + e25[c] * fspd_pkg::W_THREE;
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_line
      logic [EW-1:0] line_mem [LINE_DEPTH];

      always_ff @(posedge clock) begin
         if (line_we) begin
            line_mem[line_waddr] <= line_wdata[c];
         end
         line_q_ff[c] <= $signed(line_mem[line_raddr]);
         if (cmd.err) begin
            err_ff[c] <= sdiff[c];
         end
      end
   end

   // column and side errors
   logic [WW:0] xn;
   logic        wrap_end;

   assign xn       = {1'b0, x_ff} + (WW+1)'(1);
   assign wrap_end = (xn >= {1'b0, eff_w});

   always_ff @(posedge clock) begin
      if (reset || take_frame) begin
         col_ff <= '0;
         for (int c = 0; c < 3; c++) begin
            side_ff[c] <= '0;
         end
      end else if (take_pixel && wrap_now) begin
         for (int c = 0; c < 3; c++) begin
            side_ff[c] <= '0;
         end
      end else if (cmd.rd1) begin
         for (int c = 0; c < 3; c++) begin
            side_ff[c] <= side_new[c];
         end
      end else if (cmd.finish) begin
         if (wrap_end) begin
            col_ff <= '0;
            for (int c = 0; c < 3; c++) begin
               side_ff[c] <= '0;
            end
         end else begin
            col_ff <= xn[WW-1:0];
         end
      end
   end

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_index_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_index_ff <= idx_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_palette_index = rsp_index_ff;

   assign status.clear_done  = (clr_cnt_ff == CW'(CLR_N - 1));
   assign status.cache_hit   = cache_q_ff[8];
   assign status.search_done = (scnt_ff >= eff_n) && !v1_ff && !v2_ff;
   assign status.dither_on   = dither_ff;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

endmodule

// File: rtl/core/fspd_checker.sv
module fspd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [1:0] req_mode,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_palette_index
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_palette_index))
      else $error("stalled result changed");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item taken during clearing pass");

   a_pixel_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == fspd_pkg::MODE_PIXEL) |=> req_stall)
      else $error("pixel did not occupy the block");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_valid |=> !rsp_valid)
      else $error("result appeared in the cycle after an accept");

endmodule

bind floyd_steinberg_palette_ditherer_core fspd_checker u_fspd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_mode          (req_mode),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_palette_index (rsp_palette_index)
);
